// File: hw/rtl/crct_pkg.sv
// ----------------------------------------------------------------------------
// crct_pkg: shared types for the circle/rectangle overlap table
// Request and result item structs, request codes, status codes, states.
// ----------------------------------------------------------------------------
`default_nettype none
package crct_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_MOVED    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        rect_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_z;
        logic [15:0]        width;
        logic [15:0]        depth;
        logic [15:0]        radius;
        logic [31:0]        ignore_id;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
        logic [6:0] entry_total;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SQUARE,
        S_MOVE,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

// File: hw/rtl/circle_rect_collision_table.sv
// ----------------------------------------------------------------------------
// circle_rect_collision_table
// Table of rectangles with insert/move, remove and circle-overlap query.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// request | in  | i_req_valid/o_req_stall | crct_pkg::t_req
// result  | out | o_rsp_valid/i_rsp_stall | crct_pkg::t_rsp
// One item at a time. A lookup reads one stored rectangle at a time (memory
// read, then check); a query also squares dx and then dz for each checked
// rectangle, on the single read port and the one shared squarer. Reset
// empties the table by clearing the count; entries beyond the count are never
// checked. The request side stalls from acceptance until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module circle_rect_collision_table #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_req_valid,
    output logic                o_req_stall,
    input  wire crct_pkg::t_req i_req,
    output logic                o_rsp_valid,
    input  wire                 i_rsp_stall,
    output crct_pkg::t_rsp      o_rsp
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [31:0]        ident;
        logic signed [19:0] cx;
        logic signed [19:0] cz;
        logic [15:0]        w;
        logic [15:0]        d;
    } t_ent;

    t_ent mem [MAX_ENTRIES];

    crct_pkg::t_state r_state, n_state;
    crct_pkg::t_req   r_req;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    t_ent             r_rd;
    logic             r_hit, n_hit;
    logic [1:0]       r_status, n_status;
    logic             r_found, n_found;
    logic [AW-1:0]    r_slot, n_slot;
    logic             r_rsp_valid;
    logic [43:0]      r_sq, n_sq;   // dx^2, added to dz^2 in the second pass
    logic             r_sqz, n_sqz; // second square pending
    logic [21:0]      r_dz, n_dz;

    // memory write and read controls
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_ent          wr_data;
    logic [AW-1:0] rd_addr;

    // clamp distance along each axis in doubled units
    logic signed [22:0] lo_x, hi_x, lo_z, hi_z, px2, pz2;
    logic signed [22:0] dx_c, dz_c;
    logic [21:0]        sq_in;
    logic [43:0]        sq_out;
    logic [35:0]        reach_sq;

    assign rd_addr = r_idx[AW-1:0];

    always_comb begin
        px2  = 23'(r_req.pos_x) <<< 1;
        pz2  = 23'(r_req.pos_z) <<< 1;
        lo_x = (23'(r_rd.cx) <<< 1) - 23'($signed({1'b0, r_rd.w}));
        hi_x = (23'(r_rd.cx) <<< 1) + 23'($signed({1'b0, r_rd.w}));
        lo_z = (23'(r_rd.cz) <<< 1) - 23'($signed({1'b0, r_rd.d}));
        hi_z = (23'(r_rd.cz) <<< 1) + 23'($signed({1'b0, r_rd.d}));
        if (px2 < lo_x) begin
            dx_c = lo_x - px2;
        end else if (px2 > hi_x) begin
            dx_c = px2 - hi_x;
        end else begin
            dx_c = '0;
        end
        if (pz2 < lo_z) begin
            dz_c = lo_z - pz2;
        end else if (pz2 > hi_z) begin
            dz_c = pz2 - hi_z;
        end else begin
            dz_c = '0;
        end
    end

    // shared squaring unit
    assign sq_in    = r_sqz ? r_dz : dx_c[21:0];
    assign sq_out   = {22'd0, sq_in} * {22'd0, sq_in};
    assign reach_sq = {19'd0, r_req.radius, 1'b0} * {19'd0, r_req.radius, 1'b0};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            crct_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = crct_pkg::S_READ;
                end
            end
            crct_pkg::S_READ: begin
                if (r_idx >= r_count || r_req.req_type == crct_pkg::REQ_UNUSED ||
                    r_found) begin
                    n_state = (r_req.req_type == crct_pkg::REQ_REMOVE && r_found)
                              ? crct_pkg::S_MOVE : crct_pkg::S_RESP;
                end else begin
                    n_state = crct_pkg::S_CHECK;
                end
            end
            crct_pkg::S_CHECK: begin
                if (r_req.req_type == crct_pkg::REQ_QUERY) begin
                    if (r_req.ignore_id != '0 && r_rd.ident == r_req.ignore_id) begin
                        n_state = crct_pkg::S_READ;
                    end else begin
                        n_state = crct_pkg::S_SQUARE;
                    end
                end else if (r_rd.ident == r_req.rect_id) begin
                    // a remove reads the last entry before moving it
                    n_state = (r_req.req_type == crct_pkg::REQ_REMOVE)
                              ? crct_pkg::S_READ : crct_pkg::S_RESP;
                end else begin
                    n_state = crct_pkg::S_READ;
                end
            end
            crct_pkg::S_SQUARE: begin
                if (r_sqz) begin
                    if ((r_sq + sq_out) <= 44'(reach_sq)) begin
                        n_state = crct_pkg::S_RESP;
                    end else begin
                        n_state = crct_pkg::S_READ;
                    end
                end
            end
            crct_pkg::S_MOVE: begin
                n_state = crct_pkg::S_RESP;
            end
            crct_pkg::S_RESP: begin
                if (r_rsp_valid && !i_rsp_stall) begin
                    n_state = crct_pkg::S_IDLE;
                end
            end
            default: n_state = crct_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count  = r_count;
        n_idx    = r_idx;
        n_hit    = r_hit;
        n_status = r_status;
        n_found  = r_found;
        n_slot   = r_slot;
        n_sq     = r_sq;
        n_sqz    = r_sqz;
        n_dz     = r_dz;
        wr_en    = 1'b0;
        wr_addr  = r_slot;
        wr_data  = r_rd;
        case (r_state)
            crct_pkg::S_IDLE: begin
                n_idx    = '0;
                n_hit    = 1'b0;
                n_status = crct_pkg::ST_DONE;
                n_found  = 1'b0;
            end
            crct_pkg::S_READ: begin
                if (r_idx >= r_count || r_req.req_type == crct_pkg::REQ_UNUSED ||
                    r_found) begin
                    if (r_req.req_type == crct_pkg::REQ_INSERT) begin
                        if (r_count >= CW'(MAX_ENTRIES)) begin
                            n_status = crct_pkg::ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            wr_addr = r_count[AW-1:0];
                            wr_data = '{r_req.rect_id, r_req.pos_x, r_req.pos_z,
                                        r_req.width, r_req.depth};
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_req.req_type == crct_pkg::REQ_REMOVE && !r_found) begin
                        n_status = crct_pkg::ST_NOTFOUND;
                    end
                end
            end
            crct_pkg::S_CHECK: begin
                n_idx = r_idx + 1'b1;
                if (r_req.req_type == crct_pkg::REQ_QUERY) begin
                    n_dz  = dz_c[21:0];
                    n_sqz = 1'b0;
                end else if (r_rd.ident == r_req.rect_id) begin
                    n_slot  = r_idx[AW-1:0];
                    n_found = 1'b1;
                    if (r_req.req_type == crct_pkg::REQ_INSERT) begin
                        wr_en    = 1'b1;
                        wr_addr  = r_idx[AW-1:0];
                        wr_data  = r_rd;
                        wr_data.cx = r_req.pos_x;
                        wr_data.cz = r_req.pos_z;
                        n_status = crct_pkg::ST_MOVED;
                    end else begin
                        // fetch the last entry next
                        n_idx = r_count - 1'b1;
                    end
                end
            end
            crct_pkg::S_SQUARE: begin
                if (!r_sqz) begin
                    n_sq  = sq_out;
                    n_sqz = 1'b1;
                end else begin
                    n_sqz = 1'b0;
                    n_hit = (r_sq + sq_out) <= 44'(reach_sq);
                end
            end
            crct_pkg::S_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = r_slot;
                wr_data = r_rd;
                n_count = r_count - 1'b1;
            end
            default: ;
        endcase
    end

    // square sequencing: first pass squares dx, second dz
    // (r_sqz set means dz is on the unit)

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crct_pkg::S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
            r_sqz       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sqz       <= n_sqz;
            r_rsp_valid <= (n_state == crct_pkg::S_RESP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == crct_pkg::S_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_found  <= n_found;
        r_slot   <= n_slot;
        r_sq     <= n_sq;
        r_dz     <= n_dz;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_req_stall           = (r_state != crct_pkg::S_IDLE);
    assign o_rsp_valid           = r_rsp_valid;
    assign o_rsp.hit             = r_hit;
    assign o_rsp.status          = r_status;
    assign o_rsp.entry_total     = 7'(r_count);

endmodule
`default_nettype wire

// File: hw/rtl/crct_checker.sv
// ----------------------------------------------------------------------------
// crct_checker: port-level checks for the overlap table
// Watches handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module crct_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_req_valid,
    input wire                 o_req_stall,
    input wire crct_pkg::t_req i_req,
    input wire                 o_rsp_valid,
    input wire                 i_rsp_stall,
    input wire crct_pkg::t_rsp o_rsp
);
    // a stalled request holds
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_stall |=> i_req_valid && $stable(i_req))
        else $error("request changed under stall");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("result changed under stall");

    // no request is taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_req_stall)
        else $error("request open while result pending");

    // a hit comes only with done status
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.hit |-> o_rsp.status == crct_pkg::ST_DONE)
        else $error("hit with nonzero status");

    // reported total never exceeds 64, the default capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.entry_total <= 7'd64)
        else $error("entry total out of range");

endmodule

bind circle_rect_collision_table crct_checker u_crct_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(i_req_valid),
    .o_req_stall(o_req_stall), .i_req(i_req), .o_rsp_valid(o_rsp_valid),
    .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp)
);
`default_nettype wire
